// ===== sv/stlb_pkg.sv =====
// ----------------------------------------------------------------------------
// stlb_pkg
// shared types for the sorted table lower-bound search core: operation codes,
// sequencer states and the status word from the search sequencer
// ----------------------------------------------------------------------------
package stlb_pkg;

  // field widths fixed by the interface
  localparam int unsigned OP_W    = 2;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 11;

  // operation codes carried by an input word
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e_t;

  // search sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SRCH = 2'd1,
    ST_CMP  = 2'd2
  } state_e_t;

  // status from the search sequencer to the top level
  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } srch_stat_t;

endpackage

// ===== sv/stlb_table.sv =====
// ----------------------------------------------------------------------------
// stlb_table
// entry memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module stlb_table
  import stlb_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/stlb_search.sv =====
// ----------------------------------------------------------------------------
// stlb_search
// binary search sequencer: one memory probe and one signed compare per step,
// narrowing [lo, hi) to the first entry not below the key
// ----------------------------------------------------------------------------
module stlb_search
  import stlb_pkg::*;
#(
  parameter int unsigned CW = 11,
  parameter int unsigned AW = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] key_in,
  input  logic [CW-1:0]            count,
  input  logic                     res_free,
  input  logic signed [DATA_W-1:0] rdata,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  output logic [CW-1:0]            idx,
  output srch_stat_t               stat
);

  state_e_t                 state, state_next;
  logic [CW-1:0]            lo, lo_next;
  logic [CW-1:0]            hi, hi_next;
  logic [CW-1:0]            mid_r, mid_next;
  logic                     eq, eq_next;
  logic signed [DATA_W-1:0] key, key_next;
  logic [CW-1:0]            span;
  logic [CW-1:0]            mid;
  logic                     ge;
  logic                     hit;

  // midpoint of the open range
  assign span    = hi - lo;
  assign mid     = lo + (span >> 1);
  assign rd_addr = mid[AW-1:0];
  assign idx     = lo;

  // shared compare unit
  assign ge  = (rdata >= key);
  assign hit = (rdata == key);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // range and key registers
  always_ff @(posedge clk) begin
    lo    <= lo_next;
    hi    <= hi_next;
    mid_r <= mid_next;
    eq    <= eq_next;
    key   <= key_next;
  end

  // next state and outputs
  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid_r;
    eq_next    = eq;
    key_next   = key;
    rd_en      = 1'b0;
    stat       = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          lo_next    = '0;
          hi_next    = count;
          eq_next    = 1'b0;
          key_next   = key_in;
          state_next = ST_SRCH;
        end
      end
      ST_SRCH: begin
        stat.busy = 1'b1;
        if (lo < hi) begin
          rd_en      = 1'b1;
          mid_next   = mid;
          state_next = ST_CMP;
        end else if (res_free) begin
          // range closed: lo is the lower bound, eq tells if it matched
          stat.done  = 1'b1;
          stat.found = eq;
          state_next = ST_IDLE;
        end
      end
      ST_CMP: begin
        stat.busy = 1'b1;
        if (ge) begin
          hi_next = mid_r;
          eq_next = hit;
        end else begin
          lo_next = mid_r + CW'(1);
        end
        state_next = ST_SRCH;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // range never inverts during a search
  a_range_order: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (lo <= hi))
    else $error("search range inverted");

  // a probe is always followed by its compare
  a_probe_cmp: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == ST_CMP))
    else $error("probe not followed by compare");

  // a match can only be reported inside the filled range
  a_found_range: assert property (@(posedge clk) disable iff (rst)
    stat.found |-> (stat.done && (lo < count)))
    else $error("match reported outside filled entries");
`endif

endmodule

// ===== sv/sorted_table_lower_bound_search_core.sv =====
// ----------------------------------------------------------------------------
// sorted_table_lower_bound_search_core
// sorted table of signed words with append, clear and lower-bound query
// ----------------------------------------------------------------------------
// append, clear and unused codes: result valid in the cycle after the word is taken
// query: at most ceil(log2(entries+1)) probes, 11 for 1024
// each probe is one memory read then one compare in the shared sequencer
// one word in flight at a time; in_ready drops while a query runs
// rst clears the entry count, sequencer and output valid; memory is untouched
module sorted_table_lower_bound_search_core
  import stlb_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          operation,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     status,
  output logic                     found,
  output logic [POS_W-1:0]         position
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  logic                     accept;
  logic                     res_free;
  logic                     full;
  logic                     wr_en;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] rdata;
  logic [CW-1:0]            idx;
  logic [CW-1:0]            entry_count;
  logic [PW-1:0]            pos_ext;
  srch_stat_t               stat;
  op_e_t                    op;

  assign op       = op_e_t'(operation);
  assign res_free = !out_valid || out_ready;
  assign in_ready = !stat.busy && res_free;
  assign accept   = in_valid && in_ready;
  assign full     = (entry_count == CW'(TABLE_DEPTH));
  assign wr_en    = accept && (op == OP_APPEND) && !full;
  assign pos_ext  = PW'(idx) + PW'(1);

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (accept) begin
      unique case (op)
        OP_APPEND: begin
          if (!full) begin
            entry_count <= entry_count + CW'(1);
          end
        end
        OP_CLEAR: begin
          entry_count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && (op != OP_QUERY)) || stat.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (stat.done) begin
      status   <= 1'b0;
      found    <= stat.found;
      position <= stat.found ? pos_ext[POS_W-1:0] : '0;
    end else if (accept && (op != OP_QUERY)) begin
      status   <= (op == OP_APPEND) && full;
      found    <= 1'b0;
      position <= '0;
    end
  end

  // entry memory
  stlb_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (entry_count[AW-1:0]),
    .wdata (value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // search sequencer
  stlb_search #(
    .CW (CW),
    .AW (AW)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && (op == OP_QUERY)),
    .key_in   (value),
    .count    (entry_count),
    .res_free (res_free),
    .rdata    (rdata),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .idx      (idx),
    .stat     (stat)
  );

`ifndef SYNTH
  // count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_DEPTH))
    else $error("entry count above depth");

  // a finished search never overwrites a pending result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> res_free)
    else $error("search result overwrote pending word");

  // a taken query starts the sequencer
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_QUERY)) |=> stat.busy)
    else $error("query did not start search");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the sorted table lower-bound search core: words that append, clear,
// query or carry the unused code go in with random gaps on both handshakes;
// a scoreboard keeps its own copy of the table, predicts every result word
// and compares each field of every result word that comes out
// ----------------------------------------------------------------------------
module testbench
  import stlb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 1024;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int unsigned WORD_TARGET = 1000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic             status;
    logic             found;
    logic [POS_W-1:0] position;
  } lookup_result_t;

  // shadow table, lower-bound predictor and expected result words
  class search_scoreboard;
    logic signed [DATA_W-1:0] shadow_entries [DEPTH];
    int unsigned shadow_count;
    lookup_result_t expected_results [$];
    int unsigned errors;

    function new();
      shadow_count = 0;
      errors = 0;
    endfunction

    // predict the result word of an accepted input word
    function void note_word(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] v);
      lookup_result_t res;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      res = '0;
      if (op == OP_APPEND) begin
        if (shadow_count < DEPTH) begin
          shadow_entries[shadow_count] = v;
          shadow_count++;
        end else begin
          res.status = 1'b1;
        end
      end else if (op == OP_QUERY) begin
        lo = 0;
        hi = shadow_count;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (shadow_entries[mid] >= v) hi = mid;
          else lo = mid + 1;
        end
        if (lo < shadow_count && shadow_entries[lo] == v) begin
          res.found = 1'b1;
          res.position = POS_W'(lo + 1);
        end
      end else if (op == OP_CLEAR) begin
        shadow_count = 0;
      end
      expected_results.push_back(res);
    endfunction

    // compare a result word with the oldest prediction
    function void check_word(logic st, logic fd, logic [POS_W-1:0] pos);
      lookup_result_t exp_res;
      if (expected_results.size() == 0) begin
        $display("%0t: result word with none expected: status=%0b found=%0b position=%0d",
                 $realtime, st, fd, pos);
        errors++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (st !== exp_res.status) begin
        $display("%0t: status expected %0b got %0b", $realtime, exp_res.status, st);
        errors++;
      end
      if (fd !== exp_res.found) begin
        $display("%0t: found expected %0b got %0b", $realtime, exp_res.found, fd);
        errors++;
      end
      if (pos !== exp_res.position) begin
        $display("%0t: position expected %0d got %0d", $realtime, exp_res.position, pos);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  bit clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [OP_W-1:0] operation;
  logic signed [DATA_W-1:0] value;
  logic out_valid;
  logic out_ready;
  logic status;
  logic found;
  logic [POS_W-1:0] position;

  search_scoreboard sb;
  bit calm;
  bit hold_request;
  int unsigned words_sent;
  logic signed [DATA_W-1:0] loaded [$];
  bit sorted_ok;

  sorted_table_lower_bound_search_core #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .found(found),
    .position(position)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitor both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(operation, value);
      if (out_valid && out_ready) sb.check_word(status, found, position);
    end
  end

  // idle length, mostly short with a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // first value of a sorted run
  function automatic logic signed [DATA_W-1:0] first_value();
    if ($urandom_range(0, 4) == 0) return VAL_MIN;
    return $urandom;
  endfunction

  // next value not below the last one, clamped at the largest value
  function automatic logic signed [DATA_W-1:0] next_sorted(logic signed [DATA_W-1:0] last);
    longint nv;
    int unsigned r;
    r = $urandom_range(0, 99);
    nv = longint'(last);
    if (r < 20) nv = nv;
    else if (r < 70) nv = nv + $urandom_range(1, 8);
    else if (r < 90) nv = nv + $urandom_range(1, 1 << 24);
    else nv = nv + longint'($urandom);
    if (nv > longint'(VAL_MAX)) nv = longint'(VAL_MAX);
    return nv[DATA_W-1:0];
  endfunction

  // key at or near the loaded values, at the extremes, or random
  function automatic logic signed [DATA_W-1:0] pick_key();
    longint k;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (loaded.size() == 0 || r < 10) return $urandom;
    if (r < 15) return VAL_MIN;
    if (r < 20) return VAL_MAX;
    if (r < 70) return loaded[$urandom_range(0, loaded.size() - 1)];
    if (r < 85) begin
      k = longint'(loaded[$urandom_range(0, loaded.size() - 1)]);
      k = ($urandom_range(0, 1) == 0) ? k - 1 : k + 1;
    end else begin
      k = ($urandom_range(0, 1) == 0) ? longint'(loaded[0]) - 1 : longint'(loaded[$]) + 1;
    end
    if (k > longint'(VAL_MAX)) k = longint'(VAL_MAX);
    if (k < longint'(VAL_MIN)) k = longint'(VAL_MIN);
    return k[DATA_W-1:0];
  endfunction

  // offer one word and wait until it is taken; valid stays high into a
  // back-to-back word
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED) words_sent++;
  endtask

  task automatic clear_table();
    send_word(OP_CLEAR, $urandom);
    loaded.delete();
    sorted_ok = 1'b1;
  endtask

  // append n nondecreasing values
  task automatic load_sorted(input int unsigned n);
    logic signed [DATA_W-1:0] v;
    repeat (n) begin
      v = (loaded.size() == 0) ? first_value() : next_sorted(loaded[$]);
      send_word(OP_APPEND, v);
      if (loaded.size() < DEPTH) loaded.push_back(v);
    end
  endtask

  task automatic query_random(input int unsigned m);
    repeat (m) send_word(OP_QUERY, pick_key());
  endtask

  // random words, unsorted appends and unused codes
  task automatic noise_words(input int unsigned k);
    logic [OP_W-1:0] op;
    logic signed [DATA_W-1:0] v;
    repeat (k) begin
      op = OP_W'($urandom_range(0, 3));
      v = $urandom;
      send_word(op, v);
      if (op == OP_APPEND && loaded.size() < DEPTH) begin
        if (loaded.size() != 0 && v < loaded[$]) sorted_ok = 1'b0;
        loaded.push_back(v);
      end else if (op == OP_CLEAR) begin
        loaded.delete();
        sorted_ok = 1'b1;
      end
    end
  endtask

  // receiver: random stalls, and one long hold-off on request
  initial begin
    int unsigned stall;
    int unsigned busy;
    bit hold_done;
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      busy = calm ? 1 : $urandom_range(1, 20);
      out_ready <= 1'b1;
      repeat (busy) @(posedge clk);
    end
  end

  // stimulus
  initial begin
    bit pressure_done;
    bit fill_done;
    int unsigned r;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_APPEND;
    value = '0;
    calm = 1'b0;
    hold_request = 1'b0;
    words_sent = 0;
    sorted_ok = 1'b1;
    pressure_done = 1'b0;
    fill_done = 1'b0;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, duplicates, misses, unused code
    send_word(OP_QUERY, 0);
    send_word(OP_QUERY, VAL_MAX);
    send_word(OP_APPEND, VAL_MIN);
    send_word(OP_APPEND, VAL_MIN);
    send_word(OP_APPEND, -1);
    send_word(OP_APPEND, 0);
    send_word(OP_APPEND, 5);
    send_word(OP_APPEND, 5);
    send_word(OP_APPEND, VAL_MAX - 1);
    send_word(OP_QUERY, VAL_MIN);
    send_word(OP_QUERY, -1);
    send_word(OP_QUERY, 0);
    send_word(OP_QUERY, 5);
    send_word(OP_QUERY, 3);
    send_word(OP_QUERY, VAL_MAX);
    send_word(OP_QUERY, VAL_MAX - 1);
    send_word(OP_QUERY, 6);
    send_word(OP_UNUSED, $urandom);
    send_word(OP_QUERY, 0);
    send_word(OP_APPEND, VAL_MAX);
    send_word(OP_QUERY, VAL_MAX);
    send_word(OP_CLEAR, 0);
    send_word(OP_QUERY, VAL_MIN);
    loaded.delete();

    // random sequences
    while (words_sent < WORD_TARGET) begin
      // long receiver hold-off while words keep coming
      if (!pressure_done && words_sent > 150) begin
        hold_request = 1'b1;
        pressure_done = 1'b1;
      end
      // fill the table to the top, then overflow it
      if (!fill_done && words_sent > 160) begin
        clear_table();
        calm = 1'b1;
        load_sorted(DEPTH);
        calm = 1'b0;
        load_sorted(4);
        send_word(OP_QUERY, loaded[DEPTH-1]);
        send_word(OP_QUERY, loaded[0]);
        send_word(OP_QUERY, VAL_MAX);
        query_random(20);
        clear_table();
        fill_done = 1'b1;
      end
      calm = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 85) begin
        if (!sorted_ok || $urandom_range(0, 2) != 0) clear_table();
        load_sorted(($urandom_range(0, 9) == 0) ? $urandom_range(17, 120)
                                                : $urandom_range(1, 16));
        query_random($urandom_range(1, 12));
      end else begin
        noise_words($urandom_range(1, 8));
        if (sorted_ok) query_random($urandom_range(1, 4));
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #(6_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
